// File: hw/rtl/agr_pkg.sv
// ----------------------------------------------------------------------------
// agr_pkg: shared types and constants of the gesture recognizer
// Holds the symbol codes, register map, history and pattern dimensions, and
// the packing widths of the stream words.
// ----------------------------------------------------------------------------
package agr_pkg;

   localparam int HISTORY_DEPTH   = 8;
   localparam int PATTERN_SLOTS   = 4;
   localparam int PATTERN_SYMBOLS = 8;
   localparam int HIST_IDX_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   localparam int ACCEL_W   = 13;
   localparam int CALC_W    = 15;
   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 13;
   localparam int TIMEOUT_W = 8;
   localparam int COUNT_W   = 3;
   localparam int PWORD_W   = 28;
   localparam int PLEN_W    = 4;
   localparam int SYM_W     = 3;
   localparam int GIDX_W    = 2;

   localparam int Y_BIAS = 900;
   localparam int Z_BIAS = 400;

   // Request word: accel_x, accel_y, accel_z, time_seconds, padded to bytes.
   localparam int REQ_BITS = 3 * ACCEL_W + TIME_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   // Response word: gesture_index, recent_symbol_0..2, padded to bytes.
   localparam int RSP_BITS = GIDX_W + 3 * SYM_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [SYM_W-1:0] {
      SYM_IDLE = 3'd0,
      SYM_XP   = 3'd1,
      SYM_XN   = 3'd2,
      SYM_YP   = 3'd3,
      SYM_YN   = 3'd4,
      SYM_ZP   = 3'd5,
      SYM_ZN   = 3'd6
   } sym_type;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

   typedef enum logic [2:0] {
      REG_TRIGGER = 3'd0,
      REG_QUIET   = 3'd1,
      REG_TIMEOUT = 3'd2,
      REG_PCOUNT  = 3'd3,
      REG_PWORD0  = 3'd4,
      REG_PWORD1  = 3'd5,
      REG_PWORD2  = 3'd6,
      REG_PWORD3  = 3'd7
   } csr_reg_type;

   function automatic axis_type sym_axis(input sym_type s);
      axis_type a;
      case (s)
         SYM_XP, SYM_XN: a = AXIS_X;
         SYM_YP, SYM_YN: a = AXIS_Y;
         SYM_ZP, SYM_ZN: a = AXIS_Z;
         default:        a = AXIS_NONE;
      endcase
      return a;
   endfunction

endpackage

// File: hw/rtl/accel_gesture_recognizer_top.sv
// ----------------------------------------------------------------------------
// accel_gesture_recognizer_top: tilt gesture recognizer
// Turns accelerometer samples into direction symbols, keeps a short symbol
// history and reports when it matches one of four programmed patterns.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the sample stream: one word carries accel_x, accel_y, accel_z
//   and time_seconds. rsp_* carries a word only when a gesture is detected:
//   gesture_index and the three newest history symbols. csr_* is an APB-style
//   register port for thresholds, timeout, pattern count and pattern words;
//   write it only while no sample is in flight.
//   A sample accepted into the input register is evaluated out of it; its
//   response, if any, is written to the output register as the sample
//   advances, which waits while a pending response has not been taken.
//   One sample is taken per cycle while no response is stalled. The history
//   is updated as each sample advances, so the next always sees the state it left.
//   When the receiver stalls with a response pending, one more sample can wait
//   in the input register; then req_tready drops until the response is taken.
//   Reset clears the history to idle, the change time to zero, and the
//   registers to trigger 600, quiet 400, timeout 3 s and no patterns.
// ----------------------------------------------------------------------------
module accel_gesture_recognizer_top (
   input  logic                              clock,
   input  logic                              reset,
   // Fields from bit 0: accel_x[12:0], accel_y[25:13], accel_z[38:26],
   // time_seconds[70:39], zero padding.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [agr_pkg::REQ_W-1:0]         req_tdata,
   // Fields from bit 0: gesture_index[1:0], recent_symbol_0[4:2],
   // recent_symbol_1[7:5], recent_symbol_2[10:8], zero padding.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [agr_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [agr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [agr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [agr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // Configuration registers.
   logic [agr_pkg::LEVEL_W-1:0]   trig_ff;
   logic [agr_pkg::LEVEL_W-1:0]   quiet_ff;
   logic [agr_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [agr_pkg::COUNT_W-1:0]   pcount_ff;
   logic [agr_pkg::PWORD_W-1:0]   pword_ff [4];

   // Input stage.
   logic                               in_valid_ff;
   logic signed [agr_pkg::ACCEL_W-1:0] in_x_ff;
   logic signed [agr_pkg::ACCEL_W-1:0] in_y_ff;
   logic signed [agr_pkg::ACCEL_W-1:0] in_z_ff;
   logic [agr_pkg::TIME_W-1:0]         in_time_ff;

   // Recognizer state.
   agr_pkg::sym_type             hist_ff [agr_pkg::HISTORY_DEPTH];
   agr_pkg::sym_type             hist_in [agr_pkg::HISTORY_DEPTH];
   logic [agr_pkg::TIME_W-1:0]   last_time_ff;
   logic [agr_pkg::TIME_W-1:0]   last_time_in;

   // Output stage.
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [agr_pkg::RSP_W-1:0]    out_data_ff;
   logic [agr_pkg::RSP_W-1:0]    out_data_in;

   logic                         advance;
   logic                         csr_write;
   agr_pkg::csr_reg_type         csr_index;

   // Evaluation signals.
   logic signed [agr_pkg::CALC_W-1:0] x_s, y_s, z_s, trig_s, ntrig_s;
   logic [agr_pkg::CALC_W-1:0]        ax, ay, az, quiet_u;
   logic                              qx, qy, qz;
   agr_pkg::axis_type                 newest_axis;
   agr_pkg::sym_type                  sym;
   logic                              timed_out;
   agr_pkg::sym_type                  hist_next [agr_pkg::HISTORY_DEPTH];
   logic [agr_pkg::PATTERN_SLOTS-1:0] hit;
   logic                              match;
   logic [agr_pkg::GIDX_W-1:0]        match_idx;
   logic [agr_pkg::COUNT_W-1:0]       count_eff;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_x_ff    <= req_tdata[agr_pkg::ACCEL_W-1:0];
         in_y_ff    <= req_tdata[2*agr_pkg::ACCEL_W-1:agr_pkg::ACCEL_W];
         in_z_ff    <= req_tdata[3*agr_pkg::ACCEL_W-1:2*agr_pkg::ACCEL_W];
         in_time_ff <= req_tdata[3*agr_pkg::ACCEL_W +: agr_pkg::TIME_W];
      end
   end

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = agr_pkg::csr_reg_type'(csr_paddr[agr_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff     <= agr_pkg::LEVEL_W'(600);
         quiet_ff    <= agr_pkg::LEVEL_W'(400);
         timeout_ff  <= agr_pkg::TIMEOUT_W'(3);
         pcount_ff   <= '0;
         pword_ff[0] <= '0;
         pword_ff[1] <= '0;
         pword_ff[2] <= '0;
         pword_ff[3] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            agr_pkg::REG_TRIGGER: trig_ff     <= csr_pwdata[agr_pkg::LEVEL_W-1:0];
            agr_pkg::REG_QUIET:   quiet_ff    <= csr_pwdata[agr_pkg::LEVEL_W-1:0];
            agr_pkg::REG_TIMEOUT: timeout_ff  <= csr_pwdata[agr_pkg::TIMEOUT_W-1:0];
            agr_pkg::REG_PCOUNT:  pcount_ff   <= csr_pwdata[agr_pkg::COUNT_W-1:0];
            agr_pkg::REG_PWORD0:  pword_ff[0] <= csr_pwdata[agr_pkg::PWORD_W-1:0];
            agr_pkg::REG_PWORD1:  pword_ff[1] <= csr_pwdata[agr_pkg::PWORD_W-1:0];
            agr_pkg::REG_PWORD2:  pword_ff[2] <= csr_pwdata[agr_pkg::PWORD_W-1:0];
            agr_pkg::REG_PWORD3:  pword_ff[3] <= csr_pwdata[agr_pkg::PWORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         agr_pkg::REG_TRIGGER: csr_prdata = agr_pkg::CSR_DATA_W'(trig_ff);
         agr_pkg::REG_QUIET:   csr_prdata = agr_pkg::CSR_DATA_W'(quiet_ff);
         agr_pkg::REG_TIMEOUT: csr_prdata = agr_pkg::CSR_DATA_W'(timeout_ff);
         agr_pkg::REG_PCOUNT:  csr_prdata = agr_pkg::CSR_DATA_W'(pcount_ff);
         agr_pkg::REG_PWORD0:  csr_prdata = agr_pkg::CSR_DATA_W'(pword_ff[0]);
         agr_pkg::REG_PWORD1:  csr_prdata = agr_pkg::CSR_DATA_W'(pword_ff[1]);
         agr_pkg::REG_PWORD2:  csr_prdata = agr_pkg::CSR_DATA_W'(pword_ff[2]);
         agr_pkg::REG_PWORD3:  csr_prdata = agr_pkg::CSR_DATA_W'(pword_ff[3]);
         default:              csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Direction detection
   // ------------------------------------------------------------------------
   always_comb begin
      x_s     = agr_pkg::CALC_W'(in_x_ff);
      y_s     = agr_pkg::CALC_W'(in_y_ff) - agr_pkg::CALC_W'(agr_pkg::Y_BIAS);
      z_s     = agr_pkg::CALC_W'(in_z_ff) + agr_pkg::CALC_W'(agr_pkg::Z_BIAS);
      trig_s  = signed'(agr_pkg::CALC_W'(trig_ff));
      ntrig_s = -trig_s;
      quiet_u = agr_pkg::CALC_W'(quiet_ff);
      ax      = x_s[agr_pkg::CALC_W-1] ? agr_pkg::CALC_W'(-x_s) : agr_pkg::CALC_W'(x_s);
      ay      = y_s[agr_pkg::CALC_W-1] ? agr_pkg::CALC_W'(-y_s) : agr_pkg::CALC_W'(y_s);
      az      = z_s[agr_pkg::CALC_W-1] ? agr_pkg::CALC_W'(-z_s) : agr_pkg::CALC_W'(z_s);
      qx      = ax <= quiet_u;
      qy      = ay <= quiet_u;
      qz      = az <= quiet_u;
      newest_axis = agr_pkg::sym_axis(hist_ff[0]);

      // Fixed priority: X+, X-, Y+, Y-, Z+, Z-.
      if (x_s >= trig_s && qy && qz && newest_axis != agr_pkg::AXIS_X) begin
         sym = agr_pkg::SYM_XP;
      end else if (x_s <= ntrig_s && qy && qz && newest_axis != agr_pkg::AXIS_X) begin
         sym = agr_pkg::SYM_XN;
      end else if (y_s >= trig_s && qx && qz && newest_axis != agr_pkg::AXIS_Y) begin
         sym = agr_pkg::SYM_YP;
      end else if (y_s <= ntrig_s && qx && qz && newest_axis != agr_pkg::AXIS_Y) begin
         sym = agr_pkg::SYM_YN;
      end else if (z_s >= trig_s && qx && qy && newest_axis != agr_pkg::AXIS_Z) begin
         sym = agr_pkg::SYM_ZP;
      end else if (z_s <= ntrig_s && qx && qy && newest_axis != agr_pkg::AXIS_Z) begin
         sym = agr_pkg::SYM_ZN;
      end else begin
         sym = agr_pkg::SYM_IDLE;
      end
   end

   // Elapsed time wraps modulo 2^32.
   assign timed_out = (in_time_ff - last_time_ff) >= agr_pkg::TIME_W'(timeout_ff);

   always_comb begin
      for (int i = 0; i < agr_pkg::HISTORY_DEPTH; i++) begin
         hist_next[i] = hist_ff[i];
      end
      last_time_in = last_time_ff;
      if (sym != agr_pkg::SYM_IDLE) begin
         for (int i = agr_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_next[i] = hist_ff[i-1];
         end
         hist_next[0] = sym;
         last_time_in = in_time_ff;
      end else if (timed_out) begin
         for (int i = 0; i < agr_pkg::HISTORY_DEPTH; i++) begin
            hist_next[i] = agr_pkg::SYM_IDLE;
         end
         last_time_in = in_time_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Pattern matching
   // ------------------------------------------------------------------------
   // Pattern symbol j lines up with history entry len-1-j, newest at entry 0.
   always_comb begin
      logic [agr_pkg::PLEN_W-1:0] len;
      logic [agr_pkg::PLEN_W-1:0] idx;
      for (int p = 0; p < agr_pkg::PATTERN_SLOTS; p++) begin
         len    = pword_ff[p][agr_pkg::PWORD_W-1 -: agr_pkg::PLEN_W];
         hit[p] = (len != '0)
                  && ({1'b0, len} <= (agr_pkg::PLEN_W+1)'(agr_pkg::PATTERN_SYMBOLS))
                  && ({1'b0, len} <= (agr_pkg::PLEN_W+1)'(agr_pkg::HISTORY_DEPTH));
         for (int j = 0; j < agr_pkg::PATTERN_SYMBOLS; j++) begin
            idx = len - agr_pkg::PLEN_W'(1) - agr_pkg::PLEN_W'(j);
            if (agr_pkg::PLEN_W'(j) < len) begin
               if (pword_ff[p][agr_pkg::SYM_W*j +: agr_pkg::SYM_W]
                   != hist_next[idx[agr_pkg::HIST_IDX_W-1:0]]) begin
                  hit[p] = 1'b0;
               end
            end
         end
      end
   end

   assign count_eff = (pcount_ff > agr_pkg::COUNT_W'(agr_pkg::PATTERN_SLOTS))
                      ? agr_pkg::COUNT_W'(agr_pkg::PATTERN_SLOTS) : pcount_ff;

   always_comb begin
      match     = 1'b0;
      match_idx = '0;
      for (int p = 0; p < agr_pkg::PATTERN_SLOTS; p++) begin
         if (!match && hit[p] && (agr_pkg::COUNT_W'(p) < count_eff)) begin
            match     = 1'b1;
            match_idx = agr_pkg::GIDX_W'(p);
         end
      end
   end

   // A match clears the history in the same update that captures it into the response.
   always_comb begin
      for (int i = 0; i < agr_pkg::HISTORY_DEPTH; i++) begin
         hist_in[i] = match ? agr_pkg::SYM_IDLE : hist_next[i];
      end
   end

   always_comb begin
      logic [agr_pkg::SYM_W-1:0] third;
      third = (agr_pkg::HISTORY_DEPTH > 2)
              ? hist_next[2 % agr_pkg::HISTORY_DEPTH] : agr_pkg::SYM_IDLE;
      out_data_in  = agr_pkg::RSP_W'({third, hist_next[1], hist_next[0], match_idx});
      out_valid_in = match;
   end

   // ------------------------------------------------------------------------
   // State and output registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < agr_pkg::HISTORY_DEPTH; i++) begin
            hist_ff[i] <= agr_pkg::SYM_IDLE;
         end
         last_time_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < agr_pkg::HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         last_time_ff <= last_time_in;
         out_valid_ff <= out_valid_in;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && out_valid_in) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef ASSERT_OFF
   // A detected gesture leaves the history idle.
   assert property (@(posedge clock) disable iff (reset)
      (advance && match) |=> (hist_ff[0] == agr_pkg::SYM_IDLE))
      else $error("history not cleared after gesture");

   // Two adjacent recorded symbols never lie on the same axis.
   assert property (@(posedge clock) disable iff (reset)
      (hist_ff[0] != agr_pkg::SYM_IDLE && hist_ff[1] != agr_pkg::SYM_IDLE)
      |-> (agr_pkg::sym_axis(hist_ff[0]) != agr_pkg::sym_axis(hist_ff[1])))
      else $error("repeated axis in history");

   // A new direction records the sample time.
   assert property (@(posedge clock) disable iff (reset)
      (advance && sym != agr_pkg::SYM_IDLE) |=> (last_time_ff == $past(in_time_ff)))
      else $error("change time not recorded");

   // With the output stage empty the pipeline never holds off the input.
   assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff) |-> req_tready)
      else $error("input stalled with empty output");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the tilt gesture recognizer
// Drives sample words with random gaps and back-pressure, programs the
// register port between phases, predicts every gesture word in the bench
// and compares each received word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import agr_pkg::*;

   localparam int RAW_LIMIT    = 4000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 1130;
   localparam int PHASES       = 6;

   typedef struct {
      logic [GIDX_W-1:0] gesture_idx;
      logic [SYM_W-1:0]  recent0;
      logic [SYM_W-1:0]  recent1;
      logic [SYM_W-1:0]  recent2;
   } gesture_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Bench copy of the registers and the recognizer state.
   logic [31:0]       csr_shadow [8] = '{600, 400, 3, 0, 0, 0, 0, 0};
   sym_type           symbol_hist [HISTORY_DEPTH] = '{default: SYM_IDLE};
   logic [TIME_W-1:0] last_change_seconds = '0;
   gesture_type       expected_gestures [$];

   int  errors          = 0;
   int  samples_sent    = 0;
   int  gestures_seen   = 0;
   int  csr_writes      = 0;
   int  hold_cycles     = 0;
   bit  no_idle         = 1'b0;

   accel_gesture_recognizer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Updates the bench state with one accepted sample word and queues the
   // gesture word that it is expected to produce, if any.
   task automatic predict_gesture(input logic [REQ_W-1:0] word);
      logic signed [ACCEL_W-1:0] raw_x, raw_y, raw_z;
      logic [TIME_W-1:0]         now, elapsed;
      logic [PWORD_W-1:0]        pw;
      logic [PLEN_W-1:0]         plen;
      int                        x, y, z, ax, ay, az, trig, quiet, count, i, j, k;
      bit                        qx, qy, qz, hit;
      axis_type                  newest;
      sym_type                   pick;
      gesture_type               g;
      raw_x = word[0 +: ACCEL_W];
      raw_y = word[ACCEL_W +: ACCEL_W];
      raw_z = word[2*ACCEL_W +: ACCEL_W];
      now   = word[3*ACCEL_W +: TIME_W];
      x = raw_x;
      y = int'(raw_y) - Y_BIAS;
      z = int'(raw_z) + Z_BIAS;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      trig  = csr_shadow[REG_TRIGGER][LEVEL_W-1:0];
      quiet = csr_shadow[REG_QUIET][LEVEL_W-1:0];
      qx = (ax <= quiet);
      qy = (ay <= quiet);
      qz = (az <= quiet);
      case (symbol_hist[0])
         SYM_XP, SYM_XN: newest = AXIS_X;
         SYM_YP, SYM_YN: newest = AXIS_Y;
         SYM_ZP, SYM_ZN: newest = AXIS_Z;
         default:        newest = AXIS_NONE;
      endcase

      // Directions are tried in a fixed order; the first that qualifies wins.
      pick = SYM_IDLE;
      if (x >= trig && qy && qz && newest != AXIS_X) pick = SYM_XP;
      else if (x <= -trig && qy && qz && newest != AXIS_X) pick = SYM_XN;
      else if (y >= trig && qx && qz && newest != AXIS_Y) pick = SYM_YP;
      else if (y <= -trig && qx && qz && newest != AXIS_Y) pick = SYM_YN;
      else if (z >= trig && qx && qy && newest != AXIS_Z) pick = SYM_ZP;
      else if (z <= -trig && qx && qy && newest != AXIS_Z) pick = SYM_ZN;

      elapsed = now - last_change_seconds;
      if (pick != SYM_IDLE) begin
         for (k = HISTORY_DEPTH - 1; k > 0; k--) symbol_hist[k] = symbol_hist[k-1];
         symbol_hist[0] = pick;
         last_change_seconds = now;
      end else if (elapsed >= csr_shadow[REG_TIMEOUT][TIMEOUT_W-1:0]) begin
         for (k = 0; k < HISTORY_DEPTH; k++) symbol_hist[k] = SYM_IDLE;
         last_change_seconds = now;
      end

      count = csr_shadow[REG_PCOUNT][COUNT_W-1:0];
      if (count > PATTERN_SLOTS) count = PATTERN_SLOTS;
      hit = 1'b0;
      for (i = 0; i < count && !hit; i++) begin
         pw   = csr_shadow[int'(REG_PWORD0) + i][PWORD_W-1:0];
         plen = pw[PWORD_W-1 -: PLEN_W];
         if (plen != 0 && plen <= PATTERN_SYMBOLS && plen <= HISTORY_DEPTH) begin
            // Pattern symbol j is the j-th oldest of the last plen symbols.
            hit = 1'b1;
            for (j = 0; j < plen; j++) begin
               if (pw[SYM_W*j +: SYM_W] != symbol_hist[plen-1-j]) hit = 1'b0;
            end
            if (hit) begin
               g.gesture_idx = GIDX_W'(i);
               g.recent0 = symbol_hist[0];
               g.recent1 = symbol_hist[1];
               g.recent2 = symbol_hist[2];
               expected_gestures.push_back(g);
               for (k = 0; k < HISTORY_DEPTH; k++) symbol_hist[k] = SYM_IDLE;
            end
         end
      end
   endtask

   function automatic logic signed [ACCEL_W-1:0] clamp_raw(input int v);
      if (v > RAW_LIMIT) v = RAW_LIMIT;
      else if (v < -RAW_LIMIT) v = -RAW_LIMIT;
      return v[ACCEL_W-1:0];
   endfunction

   // Sends one sample given as bias-removed axis values; the raw word is
   // clamped to the sensor range. valid stays high after the handshake so
   // that the next word can follow back to back.
   task automatic send_sample(input int ex, input int ey, input int ez,
                              input logic [TIME_W-1:0] t);
      logic [REQ_W-1:0] word;
      int               gap;
      word = '0;
      word[0 +: ACCEL_W]         = clamp_raw(ex);
      word[ACCEL_W +: ACCEL_W]   = clamp_raw(ey + Y_BIAS);
      word[2*ACCEL_W +: ACCEL_W] = clamp_raw(ez - Z_BIAS);
      word[3*ACCEL_W +: TIME_W]  = t;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predict_gesture(word);
      samples_sent++;
   endtask

   // A clean tilt in one direction, if the code names one, with the other axes inside the quiet band.
   task automatic play_symbol(input logic [SYM_W-1:0] s, input logic [TIME_W-1:0] t);
      int e [3];
      int trig, quiet, m, k;
      trig  = csr_shadow[REG_TRIGGER][LEVEL_W-1:0];
      quiet = csr_shadow[REG_QUIET][LEVEL_W-1:0];
      for (k = 0; k < 3; k++) e[k] = int'($urandom_range(0, 2 * quiet)) - quiet;
      if (s >= SYM_XP && s <= SYM_ZN) begin
         m = trig + $urandom_range(0, 500);
         e[(s - 1) / 2] = s[0] ? m : -m;
      end
      send_sample(e[0], e[1], e[2], t);
   endtask

   // Lowers valid and waits until every predicted word has arrived and the
   // block has had time to finish a sample that produces nothing.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_gestures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type idx, input logic [31:0] value);
      logic [31:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TRIGGER, REG_QUIET: mask = (32'd1 << LEVEL_W) - 1;
         REG_TIMEOUT:            mask = (32'd1 << TIMEOUT_W) - 1;
         REG_PCOUNT:             mask = (32'd1 << COUNT_W) - 1;
         default:                mask = (32'd1 << PWORD_W) - 1;
      endcase
      csr_shadow[idx] = value & mask;
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic check_registers();
      csr_reg_type idx;
      int          i;
      for (i = 0; i < 8; i++) begin
         idx = csr_reg_type'(i);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= {idx, 2'b00};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== csr_shadow[idx]) begin
            $error("register %0d expected %h actual %h", i, csr_shadow[idx], csr_prdata);
            errors++;
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_pattern();
      logic [31:0]      w;
      logic [SYM_W-1:0] s, prev;
      int               len, j;
      // Now and then a raw word: zero length, overlong, unused codes.
      if ($urandom_range(0, 7) == 0) return $urandom();
      w    = '0;
      prev = SYM_IDLE;
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      for (j = 0; j < len; j++) begin
         do s = SYM_W'($urandom_range(1, 6)); while ((s + 1) / 2 == (prev + 1) / 2);
         w[SYM_W*j +: SYM_W] = s;
         prev = s;
      end
      w[PWORD_W-1 -: PLEN_W] = PLEN_W'(len);
      return w;
   endfunction

   task automatic test_register_access();
      int i;
      check_registers();
      for (i = 0; i < 8; i++) csr_write(csr_reg_type'(i), 32'hFFFF_FFFF);
      check_registers();
      for (i = 0; i < 8; i++) csr_write(csr_reg_type'(i), 32'h0);
      check_registers();
      csr_write(REG_TRIGGER, 600);
      csr_write(REG_QUIET, 400);
      csr_write(REG_TIMEOUT, 3);
      check_registers();
   endtask

   task automatic test_directed_cases();
      // No patterns in use: nothing is reported.
      send_sample(600, 0, 0, 0);
      // The same axis twice in a row is refused.
      send_sample(-RAW_LIMIT, 0, 0, 1);
      wait_drained();

      csr_write(REG_TIMEOUT, 10);
      csr_write(REG_PWORD0, {4'd0, 4'd2, 18'd0, SYM_YP, SYM_XP});
      csr_write(REG_PWORD1, {4'd0, 4'd0, 21'd0, SYM_XP});
      csr_write(REG_PWORD2, {4'd0, 4'd1, 21'd0, 3'd7});
      csr_write(REG_PWORD3, {4'd0, 4'd9, 21'd0, SYM_XN});
      csr_write(REG_PCOUNT, 7);
      // Trigger reached exactly with the other axes exactly at the quiet level.
      send_sample(0, 600, 400, 2);
      send_sample(RAW_LIMIT, 0, 401, 3);
      send_sample(-RAW_LIMIT, -400, 0, 4);
      send_sample(0, 0, -600, 5);
      // Sender pause, then an idle sample after the timeout clears the history.
      wait_drained();
      send_sample(0, 0, 0, 15);
      send_sample(9999, 9999, 9999, 16);
      send_sample(-9999, -9999, -9999, 17);
      wait_drained();

      // With every axis quiet and a zero trigger the fixed order decides.
      csr_write(REG_TIMEOUT, 0);
      csr_write(REG_TRIGGER, 0);
      csr_write(REG_QUIET, (1 << LEVEL_W) - 1);
      send_sample(0, 0, 0, 17);
      send_sample(0, 0, 0, 17);
      send_sample(0, 0, 0, 17);
      wait_drained();
      csr_write(REG_TRIGGER, (1 << LEVEL_W) - 1);
      csr_write(REG_QUIET, 0);
      send_sample(RAW_LIMIT, 0, 0, 17);
      wait_drained();

      // Elapsed time across the wrap of the seconds counter.
      csr_write(REG_TRIGGER, 600);
      csr_write(REG_QUIET, 400);
      csr_write(REG_TIMEOUT, 255);
      send_sample(1000, 0, 0, 32'hFFFF_FFF0);
      send_sample(0, 0, 0, 32'h0000_0010);
      send_sample(0, 1000, 0, 32'h0000_0020);
      send_sample(0, 0, 0, 32'h0000_0200);
      wait_drained();

      // A full eight-symbol pattern in the second slot.
      csr_write(REG_PWORD1, {4'd0, 4'd8, SYM_XN, SYM_ZP, SYM_YN, SYM_XP,
                             SYM_ZN, SYM_YP, SYM_XN, SYM_ZP});
      play_symbol(SYM_ZP, 32'h300);
      play_symbol(SYM_XN, 32'h300);
      play_symbol(SYM_YP, 32'h301);
      play_symbol(SYM_ZN, 32'h301);
      play_symbol(SYM_XP, 32'h302);
      play_symbol(SYM_YN, 32'h302);
      play_symbol(SYM_ZP, 32'h303);
      play_symbol(SYM_XN, 32'h303);
      wait_drained();
   endtask

   // Every X+ sample completes a one-symbol gesture, so the output backs up
   // while the receiver holds off.
   task automatic test_backpressure();
      int k;
      csr_write(REG_TIMEOUT, 255);
      csr_write(REG_PWORD0, {4'd0, 4'd1, 21'd0, SYM_XP});
      csr_write(REG_PCOUNT, 1);
      no_idle     = 1'b1;
      hold_cycles = 80;
      for (k = 0; k < 40; k++) play_symbol(SYM_XP, 32'h400 + k);
      no_idle = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_gestures(input int n_items);
      int          phase, count, slot, plen, j, k;
      logic [31:0] w;
      logic [31:0] now_s;
      now_s = $urandom();
      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         no_idle = (phase == 2);
         csr_write(REG_TRIGGER, $urandom_range(100, 2500));
         csr_write(REG_QUIET, $urandom_range(0, 700));
         csr_write(REG_TIMEOUT, (phase == 0) ? 0 : (phase == 1) ? 255 : $urandom_range(1, 12));
         for (k = 0; k < PATTERN_SLOTS; k++) begin
            csr_write(csr_reg_type'(int'(REG_PWORD0) + k), random_pattern());
         end
         csr_write(REG_PCOUNT, (phase == 5) ? $urandom_range(5, 7) : $urandom_range(1, 4));
         count = 0;
         while (count < n_items / PHASES) begin
            if ($urandom_range(0, 3) != 0) begin
               // Play one programmed pattern symbol by symbol.
               slot = $urandom_range(0, PATTERN_SLOTS - 1);
               w    = csr_shadow[int'(REG_PWORD0) + slot];
               plen = w[PWORD_W-1 -: PLEN_W];
               if (plen > PATTERN_SYMBOLS) plen = PATTERN_SYMBOLS;
               if (plen == 0) plen = 1;
               for (j = 0; j < plen; j++) begin
                  now_s += $urandom_range(0, 1);
                  play_symbol(w[SYM_W*j +: SYM_W], now_s);
                  count++;
               end
            end else begin
               case ($urandom_range(0, 2))
                  0: begin
                     now_s += $urandom_range(0, 20);
                     send_sample(0, 0, 0, now_s);
                  end
                  1: begin
                     now_s = $urandom();
                     send_sample(int'($urandom_range(0, 8000)) - RAW_LIMIT,
                                 int'($urandom_range(0, 8000)) - RAW_LIMIT - Y_BIAS,
                                 int'($urandom_range(0, 8000)) - RAW_LIMIT + Z_BIAS, now_s);
                  end
                  default: begin
                     now_s += $urandom_range(0, 2);
                     play_symbol(SYM_W'($urandom_range(0, 6)), now_s);
                  end
               endcase
               count++;
            end
         end
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   // Receiver: a random stall before each word, and a long hold-off on request.
   initial begin : drive_response_ready
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : check_gestures
      gesture_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_gestures.size() == 0) begin
            $error("unexpected gesture word %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_gestures.pop_front();
            gestures_seen++;
            if (rsp_tdata[0 +: GIDX_W] !== want.gesture_idx) begin
               $error("gesture_index expected %0d actual %0d",
                      want.gesture_idx, rsp_tdata[0 +: GIDX_W]);
               errors++;
            end
            if (rsp_tdata[GIDX_W +: SYM_W] !== want.recent0) begin
               $error("recent_symbol_0 expected %0d actual %0d",
                      want.recent0, rsp_tdata[GIDX_W +: SYM_W]);
               errors++;
            end
            if (rsp_tdata[GIDX_W+SYM_W +: SYM_W] !== want.recent1) begin
               $error("recent_symbol_1 expected %0d actual %0d",
                      want.recent1, rsp_tdata[GIDX_W+SYM_W +: SYM_W]);
               errors++;
            end
            if (rsp_tdata[GIDX_W+2*SYM_W +: SYM_W] !== want.recent2) begin
               $error("recent_symbol_2 expected %0d actual %0d",
                      want.recent2, rsp_tdata[GIDX_W+2*SYM_W +: SYM_W]);
               errors++;
            end
            if (rsp_tdata[RSP_W-1:RSP_BITS] !== '0) begin
               $error("padding expected 0 actual %h", rsp_tdata[RSP_W-1:RSP_BITS]);
               errors++;
            end
         end
      end
   end

   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_directed_cases();
      test_backpressure();
      test_random_gestures(RANDOM_ITEMS);
      wait_drained();
      $display("Sent %0d samples, checked %0d gesture words, made %0d register writes.",
               samples_sent, gestures_seen, csr_writes);
      $display("Covered threshold edges, timeouts, time wrap, odd patterns and output stalls.");
      if (errors == 0 && expected_gestures.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
